### rtl/mms_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the min/max tracking stack.
// No dependencies; used by mms_merge and min_max_tracking_stack.
package mms_pkg;

    // Command codes of an input request
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Fixed field widths
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    // Value reported for max and min when the stack is empty
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_RUN      = 1'b0,
        S_POP_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] max_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     is_empty;
        t_status                  status;
    } t_out_req;

endpackage

### rtl/mms_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mms_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mms_merge.sv
`timescale 1ns / 1ps
// Extremes of a new level: folds a pushed value into the max/min of the level below.
// Depends on mms_pkg.
module mms_merge
    import mms_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_has_below,
    input  logic signed [DATA_W-1:0] i_below_max,
    input  logic signed [DATA_W-1:0] i_below_min,
    output logic signed [DATA_W-1:0] o_max,
    output logic signed [DATA_W-1:0] o_min
);

    // Keep the value itself on an empty stack, else the larger / smaller
    always_comb begin
        o_max = i_value;
        o_min = i_value;
        if (i_has_below) begin
            if (i_value < i_below_max) begin
                o_max = i_below_max;
            end
            if (i_below_min < i_value) begin
                o_min = i_below_min;
            end
        end
    end

endmodule

### rtl/min_max_tracking_stack.sv
`timescale 1ns / 1ps
// Bounded LIFO stack of signed 32-bit values that reports the count, maximum and minimum
// after every push or pop request. Each level's running max/min lives in one RAM
// (64 bits wide, STACK_DEPTH deep); the top level's extremes are also held in registers.
// A push, a push onto a full stack, a pop on an empty stack and a pop that empties the
// stack load the result at once. A pop that leaves entries behind waits in S_POP_READ:
// the new top's extremes come back from the RAM's registered read port in the cycle after.
// A result sits in an output register; while it waits to be collected the input stalls,
// and the next request is taken in the cycle that the waiting result is collected.
// No clearing pass is needed after reset. Depends on mms_pkg, mms_ram, mms_merge.
module min_max_tracking_stack
    import mms_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_out_req o_out,
    input  logic     i_out_stall
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic signed [DATA_W-1:0] r_top_max, n_top_max;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;
    logic                     r_out_valid, n_out_valid;
    t_out_req                 r_out, n_out;

    logic                     w_out_free;
    logic                     w_acc;
    logic                     w_full;
    logic                     w_zero;
    logic [CW-1:0]            w_below2;
    logic [XW-1:0]            w_cnt_ext;
    logic                     w_load;
    t_status                  w_status;
    logic signed [DATA_W-1:0] w_rep_max;
    logic signed [DATA_W-1:0] w_rep_min;
    logic signed [DATA_W-1:0] w_new_max;
    logic signed [DATA_W-1:0] w_new_min;
    logic                     w_we;
    logic [2*DATA_W-1:0]      w_rdata;

    // Handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_RUN) || !w_out_free;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_zero     = (r_count == '0);
    assign w_below2   = r_count - CW'(2);

    // Extremes of the level a push creates
    mms_merge u_merge (
        .i_value     (i_in.value),
        .i_has_below (!w_zero),
        .i_below_max (r_top_max),
        .i_below_min (r_top_min),
        .o_max       (w_new_max),
        .o_min       (w_new_min)
    );

    // Per-level extremes store; a write lands before any later read of the same level
    mms_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({w_new_max, w_new_min}),
        .i_raddr (w_below2[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Next state, stack update and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top_max   = r_top_max;
        n_top_min   = r_top_min;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_load      = 1'b0;
        w_status    = STAT_DONE;
        w_rep_max   = EMPTY_VALUE;
        w_rep_min   = EMPTY_VALUE;

        // Drop a collected result
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_RUN: begin
                if (w_acc) begin
                    if (i_in.cmd == CMD_PUSH) begin
                        w_load = 1'b1;
                        if (w_full) begin
                            w_status  = STAT_FULL;
                            w_rep_max = r_top_max;
                            w_rep_min = r_top_min;
                        end else begin
                            w_we      = 1'b1;
                            n_count   = r_count + CW'(1);
                            n_top_max = w_new_max;
                            n_top_min = w_new_min;
                            w_rep_max = w_new_max;
                            w_rep_min = w_new_min;
                        end
                    end else if (w_zero) begin
                        w_load   = 1'b1;
                        w_status = STAT_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            w_load = 1'b1;
                        end else begin
                            // Wait for the level below the popped one
                            n_state = S_POP_READ;
                        end
                    end
                end
            end
            S_POP_READ: begin
                w_load    = 1'b1;
                n_top_max = w_rdata[2*DATA_W-1:DATA_W];
                n_top_min = w_rdata[DATA_W-1:0];
                w_rep_max = w_rdata[2*DATA_W-1:DATA_W];
                w_rep_min = w_rdata[DATA_W-1:0];
                n_state   = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        // Load the result register
        w_cnt_ext = XW'(n_count);
        if (w_load) begin
            n_out_valid     = 1'b1;
            n_out.count     = w_cnt_ext[COUNT_W-1:0];
            n_out.max_value = w_rep_max;
            n_out.min_value = w_rep_min;
            n_out.is_empty  = (n_count == '0);
            n_out.status    = w_status;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top_max <= n_top_max;
        r_top_min <= n_top_min;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // A read wait follows only an accepted pop
    a_read_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_READ) |-> $past(w_acc && (i_in.cmd == CMD_POP)))
        else $error("read wait without a pop");

    // The result register is free when the read data returns
    a_out_free_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_READ) |-> !r_out_valid)
        else $error("result register busy on pop read return");

    // A push onto a non-full stack grows it by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.cmd == CMD_PUSH) && !w_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack");

endmodule

### tb/stack_check_pkg.sv
`timescale 1ns / 1ps
// Shadow model and report checker for the min/max tracking stack testbench.
// Depends on mms_pkg for the request and report types.
package stack_check_pkg;
    import mms_pkg::*;

    class stack_report_board;
        int unsigned capacity;
        int unsigned fill;
        logic signed [DATA_W-1:0] level_hi[];
        logic signed [DATA_W-1:0] level_lo[];
        t_out_req expected_reports[$];
        int errors;
        int pushes;
        int pops;
        int full_drops;
        int empty_pops;
        int deepest;

        function new(int unsigned stack_depth);
            capacity   = stack_depth;
            level_hi   = new[stack_depth];
            level_lo   = new[stack_depth];
            fill       = 0;
            errors     = 0;
            pushes     = 0;
            pops       = 0;
            full_drops = 0;
            empty_pops = 0;
            deepest    = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Apply an accepted request to the shadow stack and queue its report
        function void record_request(t_in_req req);
            logic signed [DATA_W-1:0] pushed;
            t_out_req rep;
            pushed     = req.value;
            rep.status = STAT_DONE;
            if (req.cmd == CMD_PUSH) begin
                pushes++;
                if (fill >= capacity) begin
                    rep.status = STAT_FULL;
                    full_drops++;
                end else begin
                    // each level keeps the extremes of itself and everything below
                    level_hi[fill] = pushed;
                    level_lo[fill] = pushed;
                    if (fill > 0) begin
                        if (level_hi[fill-1] > pushed) level_hi[fill] = level_hi[fill-1];
                        if (level_lo[fill-1] < pushed) level_lo[fill] = level_lo[fill-1];
                    end
                    fill++;
                end
            end else begin
                pops++;
                if (fill == 0) begin
                    rep.status = STAT_EMPTY;
                    empty_pops++;
                end else begin
                    fill--;
                end
            end
            if (fill > deepest) deepest = fill;

            rep.count    = COUNT_W'(fill);
            rep.is_empty = (fill == 0);
            if (fill == 0) begin
                rep.max_value = EMPTY_VALUE;
                rep.min_value = EMPTY_VALUE;
            end else begin
                rep.max_value = level_hi[fill-1];
                rep.min_value = level_lo[fill-1];
            end
            expected_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
            end
        endfunction

        // Match a collected report against the oldest outstanding one
        function void check_report(t_out_req seen);
            t_out_req want;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: report with no request outstanding: expected none, got %p",
                         $time, seen);
                return;
            end
            want = expected_reports.pop_front();
            compare_field("count", want.count, seen.count);
            compare_field("max_value", want.max_value, seen.max_value);
            compare_field("min_value", want.min_value, seen.min_value);
            compare_field("is_empty", want.is_empty, seen.is_empty);
            compare_field("status", want.status, seen.status);
        endfunction
    endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for min_max_tracking_stack: clock, reset, request sender, report
// receiver and monitor. Depends on mms_pkg, stack_check_pkg and the block's RTL.
module tb_top;
    import mms_pkg::*;
    import stack_check_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int RANDOM_ITEMS    = 1080;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 20;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in        = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out;
    logic     i_out_stall = 1'b0;

    int hold_off_asks = 0;
    int burst_left    = 0;

    stack_report_board sb = new(DEPTH);

    min_max_tracking_stack #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // Note accepted requests and check collected reports
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.record_request(i_in);
            if (o_out_valid && !i_out_stall) sb.check_report(o_out);
        end
    end

    // Stall the report side in stretches of varying density, or hold off when asked
    initial begin : receiver
        int seen_asks;
        int mode_left;
        int stall_pct;
        seen_asks = 0;
        mode_left = 0;
        stall_pct = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_asks != seen_asks) begin
                seen_asks = hold_off_asks;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                mode_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return EMPTY_VALUE;
            3:       return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request in bursts with random gaps, and hold it until accepted
    task automatic send_request(input logic op, input logic signed [DATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= '{cmd: op, value: data};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait for every outstanding report
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin : stimulus
        int sent;
        int run_len;
        int push_pct;
        logic op;
        sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pop, extreme values, genuine -1, ties, drain past empty
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_PUSH, 32'sh7FFF_FFFF);
        send_request(CMD_PUSH, 32'sh8000_0000);
        send_request(CMD_PUSH, EMPTY_VALUE);
        send_request(CMD_PUSH, 32'sd0);
        send_request(CMD_POP, 32'sh7FFF_FFFF);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_PUSH, EMPTY_VALUE);
        send_request(CMD_PUSH, 32'sd5);
        send_request(CMD_PUSH, -32'sd7);
        send_request(CMD_PUSH, 32'sd5);
        send_request(CMD_PUSH, -32'sd7);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_POP, 32'sd0);
        send_request(CMD_POP, 32'sd0);
        drain_reports();

        // Random runs: fill past full, drain past empty, or wander in between
        while (sent < RANDOM_ITEMS) begin
            run_len = $urandom_range(8, 90);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_pct = 90;
                4, 5, 6:    push_pct = 12;
                default:    push_pct = 50;
            endcase
            for (int k = 0; k < run_len; k++) begin
                op = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                send_request(op, pick_value());
                sent++;
                if (sent == 350) hold_off_asks <= hold_off_asks + 1;
                if (sent == 700) drain_reports();
            end
        end

        // Wait for the last reports, then let the block settle
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d pushes, %0d pops, %0d pushes refused when full,",
                 sb.pushes + sb.pops, sb.pushes, sb.pops, sb.full_drops);
        $display("%0d pops on an empty stack, deepest fill %0d entries.",
                 sb.empty_pops, sb.deepest);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS min_max_tracking_stack");
        end else begin
            $display("FAIL min_max_tracking_stack");
        end
        $finish;
    end

    // Abandon a hung run
    initial begin : watchdog
        #2_000_000;
        $display("%0t: run timed out with %0d reports outstanding", $time, sb.pending());
        $display("FAIL min_max_tracking_stack");
        $finish;
    end

endmodule
